// File: rtl/core/mjq_pkg.sv
// ----------------------------------------------------------------------------
// Minimum-jerk quintic trajectory: shared package
// Request and result types, operand descriptor of the serial scaler, state
// encodings and the small arithmetic helpers used by the sequencer.
// ----------------------------------------------------------------------------
package mjq_pkg;

  localparam int NumCoef  = 6;
  localparam int WideW    = 113;
  localparam int CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] CFG_MOVE_TIME   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CTRL_PERIOD = 2'd1;

  localparam logic [23:0] MOVE_TIME_RST   = 24'd65536;
  localparam logic [23:0] CTRL_PERIOD_RST = 24'd655;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic               req_type;
    logic [2:0]         joint;
    logic signed [31:0] start_pos;
    logic signed [31:0] start_vel;
    logic signed [31:0] start_acc;
    logic signed [31:0] target_pos;
    logic signed [31:0] target_vel;
    logic signed [31:0] target_acc;
    logic [2:0]         up_to_joint;
    logic [23:0]        tick;
  } mjq_req_t;

  typedef struct packed {
    logic [2:0]         joint_out;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [31:0] acc;
    logic               last;
  } mjq_res_t;

  typedef enum logic [1:0] {
    LIM_64,
    LIM_48,
    LIM_32
  } mjq_lim_e;

  // one scaler request: |x| * m / d, rounded or floored, with sign restored and clamped
  typedef struct packed {
    logic signed [63:0] x;
    logic [47:0]        m;
    logic               div;
    logic               rnd;
    logic [5:0]         shamt;
    logic [23:0]        divisor;
    mjq_lim_e           lim;
  } mjq_op_t;

  typedef enum logic [2:0] {
    SU_IDLE,
    SU_MUL,
    SU_HALF,
    SU_DIV,
    SU_SHIFT,
    SU_SAT
  } mjq_su_e;

  typedef enum logic [4:0] {
    SQ_IDLE,
    SQ_LD_C,
    SQ_LD_Q,
    SQ_LD_T,
    SQ_LD_T2,
    SQ_LD_Z,
    SQ_LD_S1,
    SQ_LD_S2,
    SQ_LD_S3,
    SQ_LD_E1,
    SQ_LD_E2,
    SQ_LD_N,
    SQ_LD_DIV,
    SQ_EV_RD,
    SQ_EV_INIT,
    SQ_EV_H,
    SQ_EV_FIN,
    SQ_EV_OUT
  } mjq_sq_e;

  // derivative weight of coefficient c[i+ch] in chain ch
  function automatic logic [4:0] mjq_factor(input logic [1:0] ch, input logic [2:0] i);
    logic [4:0] f;
    case (ch)
      2'd1: f = 5'(i) + 5'd1;
      2'd2: begin
        case (i)
          3'd0:    f = 5'd2;
          3'd1:    f = 5'd6;
          3'd2:    f = 5'd12;
          default: f = 5'd20;
        endcase
      end
      default: f = 5'd1;
    endcase
    return f;
  endfunction

  // symmetric saturation at +-(2^63-1)
  function automatic logic signed [63:0] mjq_sat_add(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
    logic signed [63:0] s;
    logic signed [63:0] r;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) begin
      r = SAT_MAX;
    end else if ((a[63] && b[63] && !s[63]) || (s == SAT_MIN)) begin
      r = -SAT_MAX;
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/min_jerk_quintic_trajectory_top.sv
// ----------------------------------------------------------------------------
// Minimum-jerk quintic trajectory generator
// A load request runs up to one floor divide, seven scaled multiplies and
// twelve rounded divides by T on the shared bit-serial scaler; an
// evaluate request runs, per joint, the twelve Horner steps and three output
// roundings on that same scaler.
// busy is high from acceptance until the request has finished; each
// result appears on res_o for one cycle with result_valid_o, and must be
// taken then. Configuration writes are always accepted and must only be
// issued while busy is low.
// ----------------------------------------------------------------------------
module min_jerk_quintic_trajectory_top #(
  parameter int JOINTS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  mjq_pkg::mjq_req_t            req_i,
  output logic                         result_valid_o,
  output mjq_pkg::mjq_res_t            res_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mjq_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [23:0]                  cfg_data_i
);

  logic [23:0]        move_time_q, move_time_d;
  logic [23:0]        period_q, period_d;
  logic               su_start;
  mjq_pkg::mjq_op_t   su_op;
  logic               su_done;
  logic signed [63:0] su_res;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    move_time_d = move_time_q;
    period_d    = period_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mjq_pkg::CFG_MOVE_TIME:   move_time_d = cfg_data_i;
        mjq_pkg::CFG_CTRL_PERIOD: period_d    = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      move_time_q <= mjq_pkg::MOVE_TIME_RST;
      period_q    <= mjq_pkg::CTRL_PERIOD_RST;
    end else begin
      move_time_q <= move_time_d;
      period_q    <= period_d;
    end
  end

  mjq_seq #(
    .JOINTS (JOINTS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start && !busy),
    .req_i       (req_i),
    .move_time_i (move_time_q),
    .period_i    (period_q),
    .busy_o      (busy),
    .res_valid_o (result_valid_o),
    .res_o       (res_o),
    .su_start_o  (su_start),
    .su_op_o     (su_op),
    .su_done_i   (su_done),
    .su_res_i    (su_res)
  );

  mjq_scale_unit u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (su_start),
    .op_i    (su_op),
    .done_o  (su_done),
    .res_o   (su_res)
  );

endmodule

// File: rtl/core/mjq_scale_unit.sv
// ----------------------------------------------------------------------------
// Serial scaler
// Computes |x| * m / d, rounded or floored, d a power of two or a 24-bit
// divisor, with sign restored and magnitude clamped. Bit-serial multiply then
// either a bit-serial restoring divide, one bit per cycle, or a single shift.
// ----------------------------------------------------------------------------
module mjq_scale_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  mjq_pkg::mjq_op_t   op_i,
  output logic               done_o,
  output logic signed [63:0] res_o
);

  mjq_pkg::mjq_su_e state_q, state_d;
  logic [6:0]               cnt_q, cnt_d;
  logic                     done_q, done_d;
  mjq_pkg::mjq_op_t         op_q, op_d;
  logic [63:0]              ux_q, ux_d;
  logic                     neg_q, neg_d;
  logic [mjq_pkg::WideW-1:0] w_q, w_d;
  logic [23:0]              rem_q, rem_d;
  logic signed [63:0]       res_q, res_d;

  always_comb begin
    logic [64:0]               sum;
    logic [24:0]               trial;
    logic [mjq_pkg::WideW-1:0] half;
    logic [63:0]               lim;
    logic [63:0]               mag;
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    op_d    = op_q;
    ux_d    = ux_q;
    neg_d   = neg_q;
    w_d     = w_q;
    rem_d   = rem_q;
    res_d   = res_q;
    sum     = {1'b0, w_q[111:48]} + (w_q[0] ? {1'b0, ux_q} : 65'd0);
    trial   = {rem_q, w_q[mjq_pkg::WideW-1]};
    if (!op_q.rnd) begin
      half = '0;
    end else if (op_q.div) begin
      half = mjq_pkg::WideW'(op_q.divisor[23:1]);
    end else if (op_q.shamt != 6'd0) begin
      half = mjq_pkg::WideW'(1) << (op_q.shamt - 6'd1);
    end else begin
      half = '0;
    end
    case (op_q.lim)
      mjq_pkg::LIM_48: lim = 64'h0000_7FFF_FFFF_FFFF;
      mjq_pkg::LIM_32: lim = 64'h0000_0000_7FFF_FFFF;
      default:         lim = 64'h7FFF_FFFF_FFFF_FFFF;
    endcase
    mag = (w_q > mjq_pkg::WideW'(lim)) ? lim : w_q[63:0];

    case (state_q)
      mjq_pkg::SU_IDLE: begin
        if (start_i) begin
          op_d    = op_i;
          neg_d   = op_i.x[63];
          ux_d    = op_i.x[63] ? 64'(-op_i.x) : 64'(op_i.x);
          w_d     = {65'd0, op_i.m};
          cnt_d   = 7'd47;
          state_d = mjq_pkg::SU_MUL;
        end
      end
      mjq_pkg::SU_MUL: begin
        // LSB-first shift-add, multiplier bits shift out of the low end
        w_d   = {1'b0, sum, w_q[47:1]};
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd0) begin
          state_d = mjq_pkg::SU_HALF;
        end
      end
      mjq_pkg::SU_HALF: begin
        w_d   = w_q + half;
        rem_d = '0;
        if (op_q.div) begin
          cnt_d   = 7'(mjq_pkg::WideW - 1);
          state_d = mjq_pkg::SU_DIV;
        end else begin
          state_d = mjq_pkg::SU_SHIFT;
        end
      end
      mjq_pkg::SU_DIV: begin
        // quotient bits enter where dividend bits leave
        if (trial >= {1'b0, op_q.divisor}) begin
          rem_d = 24'(trial - {1'b0, op_q.divisor});
          w_d   = {w_q[mjq_pkg::WideW-2:0], 1'b1};
        end else begin
          rem_d = trial[23:0];
          w_d   = {w_q[mjq_pkg::WideW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd0) begin
          state_d = mjq_pkg::SU_SAT;
        end
      end
      mjq_pkg::SU_SHIFT: begin
        w_d     = w_q >> op_q.shamt;
        state_d = mjq_pkg::SU_SAT;
      end
      mjq_pkg::SU_SAT: begin
        res_d   = neg_q ? -$signed(mag) : $signed(mag);
        done_d  = 1'b1;
        state_d = mjq_pkg::SU_IDLE;
      end
      default: begin
        state_d = mjq_pkg::SU_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mjq_pkg::SU_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    ux_q  <= ux_d;
    neg_q <= neg_d;
    w_q   <= w_d;
    rem_q <= rem_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == mjq_pkg::SU_IDLE)
    else $error("scaler: result strobe outside idle");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mjq_pkg::SU_DIV |-> rem_q < op_q.divisor)
    else $error("scaler: remainder not below divisor");

  a_lim32: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && op_q.lim == mjq_pkg::LIM_32) |->
      (res_q <= 64'sh7FFF_FFFF && res_q >= -64'sh7FFF_FFFF))
    else $error("scaler: 32-bit clamp exceeded");

endmodule

// File: rtl/core/mjq_seq.sv
// ----------------------------------------------------------------------------
// Trajectory sequencer
// Runs the coefficient solve for load requests and the Horner evaluation for
// evaluate requests on the shared serial scaler; owns the coefficient RAM.
// ----------------------------------------------------------------------------
module mjq_seq #(
  parameter int JOINTS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  mjq_pkg::mjq_req_t  req_i,
  input  logic [23:0]        move_time_i,
  input  logic [23:0]        period_i,
  output logic               busy_o,
  output logic               res_valid_o,
  output mjq_pkg::mjq_res_t  res_o,
  output logic               su_start_o,
  output mjq_pkg::mjq_op_t   su_op_o,
  input  logic               su_done_i,
  input  logic signed [63:0] su_res_i
);

  localparam int JW    = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int Depth = JOINTS * mjq_pkg::NumCoef;
  localparam int AW    = $clog2(Depth);

  mjq_pkg::mjq_sq_e   state_q, state_d;
  logic               issued_q, issued_d;
  mjq_pkg::mjq_req_t  req_q, req_d;
  logic [JW-1:0]      ldj_q, ldj_d;
  logic [JW-1:0]      jcnt_q, jcnt_d;
  logic [JW-1:0]      up_q, up_d;
  logic [23:0]        tq_q, tq_d;
  logic [47:0]        t2_q, t2_d;
  logic signed [63:0] d0_q, d0_d, d1_q, d1_d, d2_q, d2_d, e1_q, e1_d, x_q, x_d;
  logic signed [47:0] c_q [mjq_pkg::NumCoef];
  logic signed [47:0] c_d [mjq_pkg::NumCoef];
  logic [2:0]         k_q, k_d, idx_q, idx_d;
  logic [1:0]         ch_q, ch_d;
  logic               valid_q, valid_d;
  mjq_pkg::mjq_res_t  res_q, res_d;

  logic [47:0]        mem [Depth];
  logic [47:0]        rd_q;
  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [47:0]        wdata;

  logic [AW-1:0]      base_ld, base_ev;
  logic signed [47:0] c_sel;
  logic signed [53:0] kprod;
  logic signed [63:0] kterm;
  logic               op_state;
  logic               fin;

  assign base_ld = AW'(ldj_q) * AW'(mjq_pkg::NumCoef);
  assign base_ev = AW'(jcnt_q) * AW'(mjq_pkg::NumCoef);
  assign c_sel   = c_q[3'(idx_q + 3'(ch_q))];
  assign kprod   = 54'(c_sel) * $signed(54'(mjq_pkg::mjq_factor(ch_q, idx_q)));
  assign kterm   = 64'(kprod);
  assign fin     = issued_q && su_done_i;
  assign raddr   = base_ev + AW'((k_q == 3'd6) ? 3'd0 : k_q);

  always_comb begin
    state_d  = state_q;
    issued_d = issued_q;
    req_d    = req_q;
    ldj_d    = ldj_q;
    jcnt_d   = jcnt_q;
    up_d     = up_q;
    tq_d     = tq_q;
    t2_d     = t2_q;
    d0_d     = d0_q;
    d1_d     = d1_q;
    d2_d     = d2_q;
    e1_d     = e1_q;
    x_d      = x_q;
    c_d      = c_q;
    k_d      = k_q;
    idx_d    = idx_q;
    ch_d     = ch_q;
    valid_d  = 1'b0;
    res_d    = res_q;
    we       = 1'b0;
    waddr    = base_ld;
    wdata    = '0;
    op_state = 1'b0;
    su_op_o  = '{x: 64'sd0, m: 48'd1, div: 1'b0, rnd: 1'b1, shamt: 6'd16,
                 divisor: tq_q, lim: mjq_pkg::LIM_64};

    case (state_q)
      mjq_pkg::SQ_IDLE: begin
        if (start_i) begin
          req_d = req_i;
          k_d   = '0;
          if (req_i.req_type == mjq_pkg::REQ_LOAD) begin
            if (int'(req_i.joint) < JOINTS) begin
              ldj_d   = JW'(req_i.joint);
              state_d = mjq_pkg::SQ_LD_C;
            end
          end else begin
            jcnt_d  = '0;
            up_d    = (int'(req_i.up_to_joint) >= JOINTS) ? JW'(JOINTS - 1)
                                                          : JW'(req_i.up_to_joint);
            state_d = mjq_pkg::SQ_EV_RD;
          end
        end
      end
      mjq_pkg::SQ_LD_C: begin
        we    = 1'b1;
        waddr = base_ld + AW'(k_q);
        case (k_q)
          3'd0:    wdata = 48'(48'(req_q.start_pos) <<< 12);
          3'd1:    wdata = 48'(48'(req_q.start_vel) <<< 12);
          default: wdata = 48'(48'(req_q.start_acc) <<< 11);
        endcase
        k_d = k_q + 3'd1;
        if (k_q == 3'd2) begin
          k_d     = '0;
          state_d = mjq_pkg::SQ_LD_Q;
        end
      end
      mjq_pkg::SQ_LD_Q: begin
        if (period_i == 24'd0) begin
          tq_d    = move_time_i;
          state_d = mjq_pkg::SQ_LD_T2;
        end else begin
          // floor division, no rounding
          op_state        = 1'b1;
          su_op_o.x       = 64'(move_time_i);
          su_op_o.m       = 48'd1;
          su_op_o.div     = 1'b1;
          su_op_o.rnd     = 1'b0;
          su_op_o.divisor = period_i;
          if (fin) begin
            x_d     = su_res_i;
            state_d = mjq_pkg::SQ_LD_T;
          end
        end
      end
      mjq_pkg::SQ_LD_T: begin
        op_state      = 1'b1;
        su_op_o.x     = x_q;
        su_op_o.m     = 48'(period_i);
        su_op_o.rnd   = 1'b0;
        su_op_o.shamt = 6'd0;
        if (fin) begin
          tq_d    = su_res_i[23:0];
          state_d = mjq_pkg::SQ_LD_T2;
        end
      end
      mjq_pkg::SQ_LD_T2: begin
        if (tq_q == 24'd0) begin
          state_d = mjq_pkg::SQ_LD_Z;
        end else begin
          op_state      = 1'b1;
          su_op_o.x     = 64'(tq_q);
          su_op_o.m     = 48'(tq_q);
          su_op_o.rnd   = 1'b0;
          su_op_o.shamt = 6'd0;
          if (fin) begin
            t2_d    = su_res_i[47:0];
            state_d = mjq_pkg::SQ_LD_S1;
          end
        end
      end
      mjq_pkg::SQ_LD_Z: begin
        we    = 1'b1;
        waddr = base_ld + AW'(k_q) + AW'(3);
        wdata = '0;
        k_d   = k_q + 3'd1;
        if (k_q == 3'd2) begin
          state_d = mjq_pkg::SQ_IDLE;
        end
      end
      mjq_pkg::SQ_LD_S1: begin
        op_state  = 1'b1;
        su_op_o.x = 64'(req_q.start_vel);
        su_op_o.m = 48'(tq_q);
        if (fin) begin
          d0_d    = 64'(req_q.target_pos) - 64'(req_q.start_pos) - su_res_i;
          state_d = mjq_pkg::SQ_LD_S2;
        end
      end
      mjq_pkg::SQ_LD_S2: begin
        op_state      = 1'b1;
        su_op_o.x     = 64'(req_q.start_acc);
        su_op_o.m     = t2_q;
        su_op_o.shamt = 6'd33;
        if (fin) begin
          d0_d    = d0_q - su_res_i;
          state_d = mjq_pkg::SQ_LD_S3;
        end
      end
      mjq_pkg::SQ_LD_S3: begin
        op_state  = 1'b1;
        su_op_o.x = 64'(req_q.start_acc);
        su_op_o.m = 48'(tq_q);
        if (fin) begin
          d1_d    = 64'(req_q.target_vel) - 64'(req_q.start_vel) - su_res_i;
          d2_d    = 64'(req_q.target_acc) - 64'(req_q.start_acc);
          state_d = mjq_pkg::SQ_LD_E1;
        end
      end
      mjq_pkg::SQ_LD_E1: begin
        op_state  = 1'b1;
        su_op_o.x = d1_q;
        su_op_o.m = 48'(tq_q);
        if (fin) begin
          e1_d    = su_res_i;
          state_d = mjq_pkg::SQ_LD_E2;
        end
      end
      mjq_pkg::SQ_LD_E2: begin
        op_state      = 1'b1;
        su_op_o.x     = d2_q;
        su_op_o.m     = t2_q;
        su_op_o.shamt = 6'd33;
        if (fin) begin
          d2_d    = su_res_i; // e2 from here on
          k_d     = '0;
          state_d = mjq_pkg::SQ_LD_N;
        end
      end
      mjq_pkg::SQ_LD_N: begin
        // wrapping 64-bit combination of d0, e1, e2
        case (k_q)
          3'd0:    x_d = (d0_q <<< 3) + (d0_q <<< 1) - (e1_q <<< 2) + d2_q;
          3'd1:    x_d = d0_q - (d0_q <<< 4) + (e1_q <<< 3) - e1_q - (d2_q <<< 1);
          default: x_d = (d0_q <<< 2) + (d0_q <<< 1) - (e1_q <<< 1) - e1_q + d2_q;
        endcase
        idx_d   = '0;
        state_d = mjq_pkg::SQ_LD_DIV;
      end
      mjq_pkg::SQ_LD_DIV: begin
        op_state        = 1'b1;
        su_op_o.x       = x_q;
        su_op_o.m       = (idx_q == 3'd0) ? 48'h0000_1000_0000 : 48'd65536;
        su_op_o.div     = 1'b1;
        su_op_o.divisor = tq_q;
        su_op_o.lim     = (idx_q == k_q + 3'd2) ? mjq_pkg::LIM_48 : mjq_pkg::LIM_64;
        if (fin) begin
          x_d   = su_res_i;
          idx_d = idx_q + 3'd1;
          if (idx_q == k_q + 3'd2) begin
            we    = 1'b1;
            waddr = base_ld + AW'(k_q) + AW'(3);
            wdata = su_res_i[47:0];
            k_d   = k_q + 3'd1;
            state_d = (k_q == 3'd2) ? mjq_pkg::SQ_IDLE : mjq_pkg::SQ_LD_N;
          end
        end
      end
      mjq_pkg::SQ_EV_RD: begin
        if (k_q != 3'd0) begin
          c_d[3'(k_q - 3'd1)] = rd_q;
        end
        k_d = k_q + 3'd1;
        if (k_q == 3'd6) begin
          ch_d    = '0;
          idx_d   = 3'd5;
          state_d = mjq_pkg::SQ_EV_INIT;
        end
      end
      mjq_pkg::SQ_EV_INIT: begin
        x_d     = kterm;
        idx_d   = idx_q - 3'd1;
        state_d = mjq_pkg::SQ_EV_H;
      end
      mjq_pkg::SQ_EV_H: begin
        op_state  = 1'b1;
        su_op_o.x = x_q;
        su_op_o.m = 48'(req_q.tick);
        if (fin) begin
          x_d = mjq_pkg::mjq_sat_add(su_res_i, kterm);
          if (idx_q == 3'd0) begin
            state_d = mjq_pkg::SQ_EV_FIN;
          end else begin
            idx_d = idx_q - 3'd1;
          end
        end
      end
      mjq_pkg::SQ_EV_FIN: begin
        op_state      = 1'b1;
        su_op_o.x     = x_q;
        su_op_o.m     = 48'd1;
        su_op_o.shamt = 6'd12;
        su_op_o.lim   = mjq_pkg::LIM_32;
        if (fin) begin
          case (ch_q)
            2'd0:    res_d.pos = su_res_i[31:0];
            2'd1:    res_d.vel = su_res_i[31:0];
            default: res_d.acc = su_res_i[31:0];
          endcase
          if (ch_q == 2'd2) begin
            state_d = mjq_pkg::SQ_EV_OUT;
          end else begin
            ch_d    = ch_q + 2'd1;
            idx_d   = 3'd4 - 3'(ch_q);
            state_d = mjq_pkg::SQ_EV_INIT;
          end
        end
      end
      mjq_pkg::SQ_EV_OUT: begin
        valid_d         = 1'b1;
        res_d.joint_out = 3'(jcnt_q);
        res_d.last      = (jcnt_q == up_q);
        if (jcnt_q == up_q) begin
          state_d = mjq_pkg::SQ_IDLE;
        end else begin
          jcnt_d  = jcnt_q + JW'(1);
          k_d     = '0;
          state_d = mjq_pkg::SQ_EV_RD;
        end
      end
      default: begin
        state_d = mjq_pkg::SQ_IDLE;
      end
    endcase

    su_start_o = op_state && !issued_q;
    if (su_start_o) begin
      issued_d = 1'b1;
    end else if (fin) begin
      issued_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mjq_pkg::SQ_IDLE;
      issued_q <= 1'b0;
      valid_q  <= 1'b0;
      jcnt_q   <= '0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      valid_q  <= valid_d;
      jcnt_q   <= jcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    ldj_q <= ldj_d;
    up_q  <= up_d;
    tq_q  <= tq_d;
    t2_q  <= t2_d;
    d0_q  <= d0_d;
    d1_q  <= d1_d;
    d2_q  <= d2_d;
    e1_q  <= e1_d;
    x_q   <= x_d;
    c_q   <= c_d;
    k_q   <= k_d;
    idx_q <= idx_d;
    ch_q  <= ch_d;
    res_q <= res_d;
  end

  // coefficient RAM, entry joint*6+k holds c_k in Q20.28
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  assign busy_o      = (state_q != mjq_pkg::SQ_IDLE);
  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule
